@@ src/mhff_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhff_pkg
// Types and constants for the mail header field filter: item structs,
// name buffer sizing, field name patterns and the inserted bulk line.
// ----------------------------------------------------------------------------
package mhff_pkg;

	localparam int MAX_TAG = 32;
	localparam int IDX_W   = $clog2(MAX_TAG);
	localparam int LEN_W   = $clog2(MAX_TAG + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;

	localparam int NUM_PAT  = 7;
	localparam int PAT_MAX  = 11;
	localparam int PAT_BITS = 8 * PAT_MAX;

	localparam int PAT_ERRORS_TO   = 0;
	localparam int PAT_RETURN_PATH = 1;
	localparam int PAT_RESENT      = 2;
	localparam int PAT_SENDER      = 3;
	localparam int PAT_VIA         = 4;
	localparam int PAT_X_MAILER    = 5;
	localparam int PAT_PRECEDENCE  = 6;

	localparam int PAT_LEN [NUM_PAT] = '{9, 11, 7, 6, 3, 8, 10};
	localparam logic [PAT_BITS-1:0] PAT_STR [NUM_PAT] = '{
		"errors-to", "return-path", "resent-", "sender", "via", "x-mailer", "precedence"
	};

	localparam int BULK_LEN = 17;
	localparam int BIDX_W   = $clog2(BULK_LEN);
	localparam logic [8*BULK_LEN-1:0] BULK_STR = "Precedence: bulk\n";

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_of_run;
		logic       message_done;
	} out_item_t;

	function automatic logic [7:0] pat_char(input int p, input int i);
		if (i < PAT_LEN[p]) begin
			return PAT_STR[p][8*(PAT_LEN[p]-1-i) +: 8];
		end
		return 8'h00;
	endfunction

	function automatic logic [7:0] bulk_char(input logic [BIDX_W-1:0] i);
		return BULK_STR[8*(BULK_LEN-1-int'(i)) +: 8];
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

@@ src/mhff_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhff_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mhff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/mail_header_field_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mail_header_field_filter
// Drops the first line and unwanted header fields of a mail message, inserts
// a bulk precedence line when none was seen, then passes the body through.
// ----------------------------------------------------------------------------
// usage:
//   byte_item carries one message byte, or an end marker that closes the
//   message. filtered carries result bytes; last_of_run flags the final
//   result of an input item, message_done the final result of a message.
//   A bare end marker (byte_valid low) is sent when the end causes nothing.
//   Ordinary bytes pass at one per cycle while the receiver keeps up: the result
//   register on the cycle after acceptance, and the next item is taken then.
//   A field name is kept in a 32-entry RAM and, if the field is kept, flushed when
//   the name ends: a read setup state, then one byte per cycle; the 17-byte bulk line
//   follows at one byte per cycle. No item is taken during a burst.
//   A stalled receiver holds the output register and stops the burst and the
//   input side. Reset puts the filter at the first line of a new message; the
//   name RAM needs no clearing since only gathered entries are read.
// ----------------------------------------------------------------------------
module mail_header_field_filter
	import mhff_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_item_valid,
	output logic      byte_item_ready,
	input  in_item_t  byte_item,
	output logic      filtered_valid,
	input  logic      filtered_ready,
	output out_item_t filtered
);

	typedef enum logic [2:0] {
		PH_SKIP, PH_START, PH_TAG, PH_FIELD, PH_FIELD_NL, PH_BODY
	} phase_t;

	typedef enum logic [2:0] {
		S_IN, S_PREP, S_FLUSH, S_BULK, S_TAIL
	} seq_t;

	phase_t             phase_q, phase_n;
	logic [LEN_W-1:0]   tag_len_q, tag_len_n;
	logic [NUM_PAT-1:0] match_q, match_n;
	logic               keep_q, keep_n;
	logic               prec_q, prec_n;

	seq_t               st_q, st_n;
	logic [LEN_W-1:0]   idx_q, idx_n;
	logic [LEN_W-1:0]   flush_cnt_q;
	logic [BIDX_W-1:0]  bidx_q, bidx_n;
	logic               bulk_q, tail_q, eom_q;
	logic [7:0]         tail_byte_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               acc, emit_ok, gen_valid;
	out_item_t          gen;
	logic [7:0]         c, lc;
	logic               is_nl, is_sptab, is_term, tag_full;
	logic               fin_keep, fin_prec;
	logic [NUM_PAT-1:0] exact, match_start, match_gath;
	logic               need_flush, need_bulk, need_tail, bare;
	logic               we;
	logic [IDX_W-1:0]   waddr, raddr;
	logic [7:0]         rdata;
	logic               idx_last, bulk_last;

	mhff_ram #(.WIDTH(8), .DEPTH(MAX_TAG)) u_tag_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (c),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign c        = byte_item.in_byte;
	assign lc       = to_lower(c);
	assign is_nl    = (c == CH_NL);
	assign is_sptab = (c == CH_SPACE) || (c == CH_TAB);
	assign is_term  = (c == CH_NUL) || is_sptab || is_nl || (c == CH_COLON);
	assign tag_full = (tag_len_q >= LEN_W'(MAX_TAG));

	assign emit_ok         = !out_valid_q || filtered_ready;
	assign byte_item_ready = (st_q == S_IN) && emit_ok;
	assign acc             = byte_item_valid && byte_item_ready;
	assign filtered_valid  = out_valid_q;
	assign filtered        = out_q;

	// incremental name matching, one character per gathered byte
	always_comb begin
		for (int p = 0; p < NUM_PAT; p++) begin
			match_start[p] = (lc == pat_char(p, 0));
			match_gath[p]  = match_q[p] && ((int'(tag_len_q) >= PAT_LEN[p]) ||
				(lc == pat_char(p, int'(tag_len_q))));
			exact[p]       = match_q[p] && (int'(tag_len_q) == PAT_LEN[p]);
		end
		fin_keep = !(exact[PAT_ERRORS_TO] || exact[PAT_RETURN_PATH] || exact[PAT_SENDER] ||
			exact[PAT_VIA] || exact[PAT_X_MAILER] ||
			(match_q[PAT_RESENT] && int'(tag_len_q) >= PAT_LEN[PAT_RESENT]));
		fin_prec = exact[PAT_PRECEDENCE];
	end

	// header phase decision for one accepted item
	always_comb begin
		phase_n    = phase_q;
		tag_len_n  = tag_len_q;
		match_n    = match_q;
		keep_n     = keep_q;
		prec_n     = prec_q;
		we         = 1'b0;
		waddr      = tag_len_q[IDX_W-1:0];
		need_flush = 1'b0;
		need_bulk  = 1'b0;
		need_tail  = 1'b0;
		bare       = 1'b0;
		if (byte_item.end_of_message) begin
			case (phase_q)
				PH_TAG: begin
					need_flush = fin_keep;
					need_bulk  = !(prec_q || fin_prec);
				end
				PH_SKIP, PH_START, PH_FIELD, PH_FIELD_NL: begin
					need_bulk = !prec_q;
				end
				default: begin
				end
			endcase
			bare      = !need_flush && !need_bulk;
			phase_n   = PH_SKIP;
			tag_len_n = '0;
			keep_n    = 1'b1;
			prec_n    = 1'b0;
		end else begin
			case (phase_q)
				PH_SKIP: begin
					if (is_nl) begin
						phase_n = PH_START;
					end
				end
				PH_START, PH_FIELD_NL: begin
					if (phase_q == PH_FIELD_NL && is_sptab) begin
						need_tail = keep_q;
						phase_n   = PH_FIELD;
					end else if (is_nl) begin
						need_bulk = !prec_q;
						need_tail = 1'b1;
						phase_n   = PH_BODY;
					end else begin
						we        = 1'b1;
						waddr     = '0;
						tag_len_n = LEN_W'(1);
						match_n   = match_start;
						phase_n   = PH_TAG;
					end
				end
				PH_TAG: begin
					if (tag_full || is_term) begin
						keep_n     = fin_keep;
						prec_n     = prec_q || fin_prec;
						need_flush = fin_keep;
						need_tail  = fin_keep;
						phase_n    = is_nl ? PH_FIELD_NL : PH_FIELD;
					end else begin
						we        = 1'b1;
						tag_len_n = tag_len_q + LEN_W'(1);
						match_n   = match_gath;
					end
				end
				PH_FIELD: begin
					need_tail = keep_q;
					if (is_nl) begin
						phase_n = PH_FIELD_NL;
					end
				end
				default: begin
					need_tail = 1'b1;
				end
			endcase
		end
	end

	assign idx_last  = (LEN_W'(idx_q + LEN_W'(1)) == flush_cnt_q);
	assign bulk_last = (bidx_q == BIDX_W'(BULK_LEN - 1));

	// result sequencer: name flush, bulk line, pending byte
	always_comb begin
		st_n      = st_q;
		idx_n     = idx_q;
		bidx_n    = bidx_q;
		gen_valid = 1'b0;
		gen       = '0;
		unique case (st_q)
			S_IN: begin
				if (acc) begin
					idx_n  = '0;
					bidx_n = '0;
					if (need_flush) begin
						st_n = S_PREP;
					end else if (need_bulk) begin
						st_n = S_BULK;
					end else if (need_tail) begin
						gen_valid       = 1'b1;
						gen.out_byte    = c;
						gen.byte_valid  = 1'b1;
						gen.last_of_run = 1'b1;
					end else if (bare) begin
						gen_valid        = 1'b1;
						gen.last_of_run  = 1'b1;
						gen.message_done = 1'b1;
					end
				end
			end
			S_PREP: begin
				st_n = S_FLUSH;
			end
			S_FLUSH: begin
				if (emit_ok) begin
					gen_valid        = 1'b1;
					gen.out_byte     = rdata;
					gen.byte_valid   = 1'b1;
					gen.last_of_run  = idx_last && !bulk_q && !tail_q;
					gen.message_done = idx_last && !bulk_q && !tail_q && eom_q;
					idx_n            = idx_q + LEN_W'(1);
					if (idx_last) begin
						st_n = bulk_q ? S_BULK : (tail_q ? S_TAIL : S_IN);
					end
				end
			end
			S_BULK: begin
				if (emit_ok) begin
					gen_valid        = 1'b1;
					gen.out_byte     = bulk_char(bidx_q);
					gen.byte_valid   = 1'b1;
					gen.last_of_run  = bulk_last && !tail_q;
					gen.message_done = bulk_last && !tail_q && eom_q;
					bidx_n           = bidx_q + BIDX_W'(1);
					if (bulk_last) begin
						st_n = tail_q ? S_TAIL : S_IN;
					end
				end
			end
			S_TAIL: begin
				if (emit_ok) begin
					gen_valid       = 1'b1;
					gen.out_byte    = tail_byte_q;
					gen.byte_valid  = 1'b1;
					gen.last_of_run = 1'b1;
					st_n            = S_IN;
				end
			end
			default: begin
				st_n = S_IN;
			end
		endcase
		raddr = idx_n[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			tag_len_q   <= '0;
			match_q     <= '0;
			keep_q      <= 1'b1;
			prec_q      <= 1'b0;
			st_q        <= S_IN;
			idx_q       <= '0;
			bidx_q      <= '0;
			flush_cnt_q <= '0;
			bulk_q      <= 1'b0;
			tail_q      <= 1'b0;
			eom_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_n;
			idx_q  <= idx_n;
			bidx_q <= bidx_n;
			if (acc) begin
				phase_q     <= phase_n;
				tag_len_q   <= tag_len_n;
				match_q     <= match_n;
				keep_q      <= keep_n;
				prec_q      <= prec_n;
				flush_cnt_q <= tag_len_q;
				bulk_q      <= need_bulk;
				tail_q      <= need_tail;
				eom_q       <= byte_item.end_of_message;
			end
			if (gen_valid) begin
				out_valid_q <= 1'b1;
			end else if (filtered_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tail_byte_q <= c;
		end
		if (gen_valid) begin
			out_q <= gen;
		end
	end

	a_flush_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FLUSH) |-> (idx_q < flush_cnt_q))
		else $error("name flush index beyond gathered length");

	a_tag_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tag_len_q <= LEN_W'(MAX_TAG))
		else $error("name length beyond buffer size");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.message_done) |-> out_q.last_of_run)
		else $error("message end not on last result of item");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.byte_valid) |-> out_q.message_done)
		else $error("empty result outside message end");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && byte_item.end_of_message) |=> (phase_q == PH_SKIP && tag_len_q == '0 && !prec_q))
		else $error("filter state not restored after message end");

endmodule

@@ sim/tb_mail_header_field_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mail_header_field_filter
// Self-checking bench for the mail header field filter. Messages are sent as
// byte items, each closed by an end item. A behavioral copy of the filter
// predicts every output item, and the output stream is compared with it in
// order. Directed messages cover dropped and kept names, the precedence
// field, the full name buffer, odd terminators and early ends. Random
// messages follow, with random idling on both sides and a quiet tail at the
// end.
// ----------------------------------------------------------------------------
module tb_mail_header_field_filter;
	import mhff_pkg::*;

	typedef enum logic [2:0] {
		S_FIRST_LINE,
		S_LINE_START,
		S_NAME,
		S_FIELD,
		S_FIELD_NL,
		S_BODY
	} filt_state_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      byte_item_valid;
	logic      byte_item_ready;
	in_item_t  byte_item;
	logic      filtered_valid;
	logic      filtered_ready;
	out_item_t filtered;

	// filter model state
	filt_state_t state;
	logic [7:0]  name_buf [MAX_TAG];
	int          name_len;
	bit          keep_cur;
	bit          prec_seen;

	out_item_t   filtered_q [$];
	logic [7:0]  msg [$];
	int          error_count = 0;
	int          sent_count = 0;
	bit          send_idle_en = 1'b1;
	bit          recv_idle_en = 1'b1;

	string field_names [12] = '{
		"errors-to", "return-path", "resent-", "resent-cc", "sender", "via",
		"x-mailer", "precedence", "subject", "to", "vi", "senders"
	};

	mail_header_field_filter DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_item_valid (byte_item_valid),
		.byte_item_ready (byte_item_ready),
		.byte_item       (byte_item),
		.filtered_valid  (filtered_valid),
		.filtered_ready  (filtered_ready),
		.filtered        (filtered)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void reset_filter_model();
		state = S_FIRST_LINE;
		name_len = 0;
		keep_cur = 1'b1;
		prec_seen = 1'b0;
		for (int i = 0; i < MAX_TAG; i++) name_buf[i] = 8'h00;
	endfunction

	function automatic void push_out(input logic [7:0] b, input logic v);
		out_item_t r;
		r.out_byte = b;
		r.byte_valid = v;
		r.last_of_run = 1'b0;
		r.message_done = 1'b0;
		filtered_q.push_back(r);
	endfunction

	function automatic bit name_matches(input string pat, input bit prefix);
		logic [7:0] c;
		if (prefix ? (name_len < pat.len()) : (name_len != pat.len())) return 1'b0;
		for (int i = 0; i < pat.len(); i++) begin
			c = name_buf[i];
			if (c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
			if (c != pat[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void close_name();
		bit keep;
		keep = !(name_matches("errors-to", 1'b0) || name_matches("return-path", 1'b0) ||
			name_matches("resent-", 1'b1) || name_matches("sender", 1'b0) ||
			name_matches("via", 1'b0) || name_matches("x-mailer", 1'b0));
		if (name_matches("precedence", 1'b0)) prec_seen = 1'b1;
		if (keep) begin
			for (int i = 0; i < name_len; i++) push_out(name_buf[i], 1'b1);
		end
		keep_cur = keep;
		name_len = 0;
		state = S_FIELD;
	endfunction

	function automatic void add_bulk_line();
		string bulk_text;
		bulk_text = "Precedence: bulk\n";
		if (!prec_seen) begin
			for (int i = 0; i < bulk_text.len(); i++) push_out(bulk_text[i], 1'b1);
		end
	endfunction

	function automatic void filter_byte(input logic [7:0] c);
		bit done;
		done = 1'b0;
		while (!done) begin
			case (state)
				S_FIRST_LINE: begin
					if (c == CH_NL) state = S_LINE_START;
					done = 1'b1;
				end
				S_LINE_START: begin
					if (c == CH_NL) begin
						add_bulk_line();
						push_out(c, 1'b1);
						state = S_BODY;
					end else begin
						name_buf[0] = c;
						name_len = 1;
						state = S_NAME;
					end
					done = 1'b1;
				end
				S_NAME: begin
					if (name_len >= MAX_TAG || c == CH_NUL || c == CH_SPACE || c == CH_TAB ||
						c == CH_NL || c == CH_COLON) begin
						close_name();
					end else begin
						name_buf[name_len] = c;
						name_len++;
						done = 1'b1;
					end
				end
				S_FIELD: begin
					if (keep_cur) push_out(c, 1'b1);
					if (c == CH_NL) state = S_FIELD_NL;
					done = 1'b1;
				end
				S_FIELD_NL: begin
					if (c == CH_SPACE || c == CH_TAB) begin
						if (keep_cur) push_out(c, 1'b1);
						state = S_FIELD;
						done = 1'b1;
					end else begin
						state = S_LINE_START;
					end
				end
				default: begin
					push_out(c, 1'b1);
					done = 1'b1;
				end
			endcase
		end
	endfunction

	function automatic void filter_item(input in_item_t it);
		int        first;
		out_item_t tail;
		first = filtered_q.size();
		if (it.end_of_message) begin
			if (state == S_NAME) close_name();
			if (state <= S_FIELD_NL) add_bulk_line();
			if (filtered_q.size() == first) push_out(8'h00, 1'b0);
			tail = filtered_q.pop_back();
			tail.last_of_run = 1'b1;
			tail.message_done = 1'b1;
			filtered_q.push_back(tail);
			reset_filter_model();
		end else begin
			filter_byte(it.in_byte);
			if (filtered_q.size() > first) begin
				tail = filtered_q.pop_back();
				tail.last_of_run = 1'b1;
				filtered_q.push_back(tail);
			end
		end
	endfunction

	task automatic send_item(input logic [7:0] b, input logic eom);
		in_item_t it;
		if (send_idle_en && $urandom_range(0, 4) == 0) begin
			byte_item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		it.in_byte = b;
		it.end_of_message = eom;
		byte_item <= it;
		byte_item_valid <= 1'b1;
		@(posedge clk);
		while (!byte_item_ready) @(posedge clk);
		filter_item(it);
		sent_count++;
	endtask

	task automatic send_message();
		foreach (msg[i]) send_item(msg[i], 1'b0);
		send_item(8'($urandom), 1'b1);
		msg.delete();
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
	endfunction

	// letters come out in random case
	function automatic void add_name(input string s);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) == 1) c = c - 8'h20;
			msg.push_back(c);
		end
	endfunction

	function automatic void add_random_text(input int n);
		repeat (n) msg.push_back(8'($urandom_range(33, 126)));
	endfunction

	function automatic void add_random_field();
		int sep;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(MAX_TAG - 4, MAX_TAG + 4))
				msg.push_back(8'($urandom_range(97, 122)));
		end else begin
			add_name(field_names[$urandom_range(0, 11)]);
		end
		sep = $urandom_range(0, 5);
		case (sep)
			0: msg.push_back(CH_SPACE);
			1: msg.push_back(CH_TAB);
			2: msg.push_back(CH_NUL);
			default: msg.push_back(CH_COLON);
		endcase
		add_random_text($urandom_range(0, 6));
		msg.push_back(CH_NL);
		if ($urandom_range(0, 3) == 0) begin
			msg.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			add_random_text($urandom_range(0, 4));
			msg.push_back(CH_NL);
		end
	endfunction

	task automatic random_message();
		int kind;
		int cut;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// noise
			repeat ($urandom_range(0, 30))
				msg.push_back($urandom_range(0, 3) == 0 ? CH_NL : 8'($urandom));
		end else begin
			add_random_text($urandom_range(0, 6));
			msg.push_back(CH_NL);
			repeat ($urandom_range(0, 4)) add_random_field();
			if ($urandom_range(0, 7) != 0) begin
				msg.push_back(CH_NL);
				repeat ($urandom_range(0, 12)) msg.push_back(8'($urandom));
			end
			if (kind == 1 && msg.size() > 0) begin
				// broken message, cut at a random point
				cut = $urandom_range(0, msg.size() - 1);
				while (msg.size() > cut) void'(msg.pop_back());
			end
		end
		send_message();
	endtask

	task automatic test_short_messages();
		send_message();
		add_text("From someone");
		send_message();
		add_text("From a\n");
		send_message();
		add_text("F\n\n");
		send_message();
	endtask

	task automatic test_dropped_fields();
		add_text("x\n");
		add_name("errors-to");
		add_text(":\n");
		add_name("return-path");
		add_text(": b\n x\n");
		add_name("resent-date");
		add_text(":\n\tm\n");
		add_name("resent-");
		add_text(":\n");
		add_name("sender");
		add_text(" d\n");
		add_name("via");
		add_text("\n");
		add_name("x-mailer");
		add_text(":e\n");
		add_text("resent:\nvias:\nsende:\nTo: a\n b\n\nz");
		send_message();
	endtask

	task automatic test_precedence_field();
		add_text("x\n");
		add_name("precedence");
		add_text(": l\nTo: a\n\n");
		msg.push_back(8'hff);
		msg.push_back(CH_NUL);
		send_message();
		// end inside the header after a precedence field
		add_text("x\nPRECEDENCE:j\nCc: b\n");
		send_message();
	endtask

	task automatic test_name_limits();
		add_text("x\n");
		// full buffer, next ordinary byte closes the name and goes to the field
		repeat (MAX_TAG) msg.push_back(8'h61);
		add_text("Q\n");
		add_text("ab");
		msg.push_back(CH_NUL);
		add_text("z\ncd\te\n");
		msg.push_back(CH_NUL);
		add_text("n\n:c\nsubj");
		send_message();
		add_text("x\n\tt: v\n");
		send_message();
		add_text("x\n sender\n");
		send_message();
	endtask

	task automatic test_random_messages();
		int stop_at;
		stop_at = sent_count + 40;
		while (sent_count < stop_at) random_message();
	endtask

	task automatic test_quiet_tail();
		int stop_at;
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		stop_at = sent_count + 20;
		while (sent_count < stop_at) random_message();
	endtask

	// receiver side with random stalls
	initial begin
		filtered_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (recv_idle_en && $urandom_range(0, 5) == 0) begin
				filtered_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				filtered_ready <= 1'b1;
			end else begin
				filtered_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && filtered_valid && filtered_ready) begin
			if (filtered_q.size() == 0) begin
				$error("unexpected item: out_byte %h byte_valid %b", filtered.out_byte,
					filtered.byte_valid);
				error_count++;
			end else begin
				want = filtered_q.pop_front();
				if (filtered.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, actual %h", want.out_byte, filtered.out_byte);
					error_count++;
				end
				if (filtered.byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %b, actual %b", want.byte_valid,
						filtered.byte_valid);
					error_count++;
				end
				if (filtered.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %b, actual %b", want.last_of_run,
						filtered.last_of_run);
					error_count++;
				end
				if (filtered.message_done !== want.message_done) begin
					$error("message_done: expected %b, actual %b", want.message_done,
						filtered.message_done);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_item_valid = 1'b0;
		byte_item = '0;
		reset_filter_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_messages();
		test_dropped_fields();
		test_precedence_field();
		test_name_limits();
		test_random_messages();
		test_quiet_tail();
		byte_item_valid <= 1'b0;
		for (int n = 0; filtered_q.size() != 0 && n < 100000; n++) @(posedge clk);
		repeat (40) @(posedge clk);
		if (filtered_q.size() != 0) begin
			$error("%0d expected items never arrived", filtered_q.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ mail_header_field_filter.f @@
src/mhff_pkg.sv
src/mhff_ram.sv
src/mail_header_field_filter.sv
sim/tb_mail_header_field_filter.sv
